// File: hw/rtl/sws_pkg.sv
`default_nettype none

package sws_pkg;

    localparam int NUM_DIMS  = 16;
    localparam int COORD_W   = 16;
    localparam int POINT_W   = NUM_DIMS * COORD_W;
    localparam int TIME_W    = 32;
    localparam int LIFE_W    = 20;
    localparam int KIND_W    = 3;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 20'd10000;

    localparam logic [KIND_W-1:0] KIND_ACCEPT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REJECT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DROP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXPIRE = 3'd4;

    typedef struct packed {
        logic                valid;
        logic [TIME_W-1:0]   arrival;
        logic [POINT_W-1:0]  point;
        logic                flag;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic cmp;
        logic exp;
    } t_cell_ctl;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_REJ,
        S_SCAN,
        S_EXPC,
        S_VERD,
        S_EXP
    } t_state;

    // True when every coordinate of a is less than or equal to that of b.
    function automatic logic all_le(input logic [POINT_W-1:0] a,
                                    input logic [POINT_W-1:0] b);
        logic r;
        r = 1'b1;
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (a[d*COORD_W +: COORD_W] > b[d*COORD_W +: COORD_W]) begin
                r = 1'b0;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sws_cell.sv
`default_nettype none

module sws_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sws_pkg::t_cell_ctl            i_ctl,
    input  sws_pkg::t_entry               i_entry,
    input  logic [sws_pkg::POINT_W-1:0]   i_point,
    input  logic [sws_pkg::TIME_W-1:0]    i_now,
    input  logic [sws_pkg::LIFE_W-1:0]    i_lifetime,
    output sws_pkg::t_entry               o_entry,
    output logic                          o_dom
);
    import sws_pkg::*;

    logic               r_valid;
    logic [TIME_W-1:0]  r_arrival;
    logic [POINT_W-1:0] r_point;
    logic               r_flag;
    logic               r_dom;
    logic [TIME_W-1:0]  age;
    logic               expire;

    assign age    = i_now - r_arrival;
    assign expire = ({1'b0, age} + 33'd1) >= {{(TIME_W + 1 - LIFE_W){1'b0}}, i_lifetime};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_arrival <= i_entry.arrival;
            r_point   <= i_entry.point;
            r_flag    <= i_entry.flag;
        end else if (i_ctl.cmp) begin
            r_flag <= r_valid && all_le(i_point, r_point);
            r_dom  <= r_valid && all_le(r_point, i_point);
        end else if (i_ctl.exp) begin
            r_flag <= r_valid && expire;
        end
    end

    assign o_entry = '{valid: r_valid, arrival: r_arrival, point: r_point, flag: r_flag};
    assign o_dom   = r_dom;

endmodule

`default_nettype wire

// File: hw/rtl/sliding_window_skyline.sv
// A point is accepted only in idle, reached again after the scan, verdict and expiry pass
// for that point, so no new point is taken before the block is through with the last one.
// The stored entries rotate through a row of cells, one entry reaching the head each cycle,
// once for removals and insertion and once for expiry; a stalled result beat stalls the row.
// At the earliest, the first result beat is loaded in the scan, after compare and reject.
// Synchronous active-low reset empties the store, zeroes the tick and sets lifetime to 10000.
`default_nettype none

module sliding_window_skyline #(
    parameter int SKYLINE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_coords_0_3,
    input  logic [63:0] i_coords_4_7,
    input  logic [63:0] i_coords_8_11,
    input  logic [63:0] i_coords_12_15,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_kind,
    output logic [31:0] o_entry_time,
    output logic [63:0] o_out_coords_0_3,
    output logic [63:0] o_out_coords_4_7,
    output logic [63:0] o_out_coords_8_11,
    output logic [63:0] o_out_coords_12_15,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [19:0] i_cfg_data
);
    import sws_pkg::*;

    localparam int CW = (SKYLINE_ENTRIES > 1) ? $clog2(SKYLINE_ENTRIES) : 1;

    t_state             r_state, n_state;
    logic [CW-1:0]      r_cnt;
    logic [POINT_W-1:0] r_p;
    logic               r_rej;
    logic               r_found;
    logic [TIME_W-1:0]  r_tick;
    logic [LIFE_W-1:0]  r_life;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [TIME_W-1:0]  r_time;
    logic [POINT_W-1:0] r_opt;
    logic               r_last;

    t_entry             w_ent [SKYLINE_ENTRIES];
    logic               w_dom [SKYLINE_ENTRIES];
    t_cell_ctl          ctl;
    t_entry             head;
    t_entry             tail;
    logic               any_dom;
    logic               any_exp;
    logic               rest_exp;
    logic               step_ok;
    logic               cnt_done;
    logic               adv;
    logic               ins;
    logic               load;
    logic [KIND_W-1:0]  ld_kind;
    logic [TIME_W-1:0]  ld_time;
    logic [POINT_W-1:0] ld_pt;
    logic               ld_last;
    logic               accept;

    genvar g;
    generate
        for (g = 0; g < SKYLINE_ENTRIES; g++) begin : g_cell
            t_entry nxt;
            if (g == SKYLINE_ENTRIES - 1) begin : g_tail
                assign nxt = tail;
            end else begin : g_mid
                assign nxt = w_ent[g+1];
            end
            sws_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_entry    (nxt),
                .i_point    (r_p),
                .i_now      (r_tick),
                .i_lifetime (r_life),
                .o_entry    (w_ent[g]),
                .o_dom      (w_dom[g])
            );
        end
    endgenerate

    always_comb begin
        any_dom  = 1'b0;
        any_exp  = 1'b0;
        rest_exp = 1'b0;
        for (int i = 0; i < SKYLINE_ENTRIES; i++) begin
            any_dom = any_dom | w_dom[i];
            any_exp = any_exp | w_ent[i].flag;
            if (i > 0) begin
                rest_exp = rest_exp | w_ent[i].flag;
            end
        end
    end

    assign head     = w_ent[0];
    assign step_ok  = !r_out_valid || i_out_ready;
    assign cnt_done = (r_cnt == CW'(SKYLINE_ENTRIES - 1));
    assign accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_in_ready = 1'b0;
        ctl        = '0;
        tail       = head;
        adv        = 1'b0;
        ins        = 1'b0;
        load       = 1'b0;
        ld_kind    = KIND_ACCEPT;
        ld_time    = r_tick;
        ld_pt      = r_p;
        ld_last    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_CMP: begin
                ctl.cmp = 1'b1;
            end
            S_REJ: begin
            end
            S_SCAN: begin
                ins = !r_rej && !r_found && (!head.valid || head.flag);
                if (!r_rej && head.valid && head.flag) begin
                    adv        = step_ok;
                    load       = step_ok;
                    ld_kind    = KIND_REMOVE;
                    ld_time    = head.arrival;
                    ld_pt      = head.point;
                    tail.valid = 1'b0;
                end else begin
                    adv = 1'b1;
                end
                if (ins) begin
                    tail = '{valid: 1'b1, arrival: r_tick, point: r_p, flag: 1'b0};
                end
                ctl.shift = adv;
            end
            S_EXPC: begin
                ctl.exp = 1'b1;
            end
            S_VERD: begin
                load    = step_ok;
                ld_kind = r_rej ? KIND_REJECT : (r_found ? KIND_ACCEPT : KIND_DROP);
                ld_last = !any_exp;
            end
            S_EXP: begin
                if (head.flag) begin
                    adv     = step_ok;
                    load    = step_ok;
                    ld_kind = KIND_EXPIRE;
                    ld_time = head.arrival;
                    ld_pt   = head.point;
                    ld_last = !rest_exp;
                end else begin
                    adv = 1'b1;
                end
                tail.valid = head.valid && !head.flag;
                tail.flag  = 1'b0;
                ctl.shift  = adv;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in_valid) n_state = S_CMP;
            S_CMP:  n_state = S_REJ;
            S_REJ:  n_state = S_SCAN;
            S_SCAN: if (adv && cnt_done) n_state = S_EXPC;
            S_EXPC: n_state = S_VERD;
            S_VERD: if (step_ok) n_state = S_EXP;
            S_EXP:  if (adv && cnt_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_found     <= 1'b0;
            r_rej       <= 1'b0;
            r_tick      <= '0;
            r_life      <= LIFETIME_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_life <= i_cfg_data;
            end
            if (adv) begin
                r_cnt <= cnt_done ? '0 : r_cnt + 1'b1;
            end
            if (accept) begin
                r_found <= 1'b0;
            end else if (adv && ins) begin
                r_found <= 1'b1;
            end
            if (r_state == S_REJ) begin
                r_rej <= any_dom;
            end
            if (r_state == S_EXP && adv && cnt_done) begin
                r_tick <= r_tick + 1'b1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_p <= {i_coords_12_15, i_coords_8_11, i_coords_4_7, i_coords_0_3};
        end
        if (load) begin
            r_kind <= ld_kind;
            r_time <= ld_time;
            r_opt  <= ld_pt;
            r_last <= ld_last;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_kind       = r_kind;
    assign o_entry_time       = r_time;
    assign o_out_coords_0_3   = r_opt[63:0];
    assign o_out_coords_4_7   = r_opt[127:64];
    assign o_out_coords_8_11  = r_opt[191:128];
    assign o_out_coords_12_15 = r_opt[255:192];
    assign o_last             = r_last;

endmodule

`default_nettype wire

// File: tb/sv/tb_sliding_window_skyline.sv
`timescale 1ns / 1ps
`default_nettype none

module tb_sliding_window_skyline;
    import sws_pkg::*;

    localparam int ENTRIES  = 32;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TIME_W-1:0]  etime;
        logic [POINT_W-1:0] point;
        logic               last;
    } t_event;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [63:0]        i_coords_0_3 = '0;
    logic [63:0]        i_coords_4_7 = '0;
    logic [63:0]        i_coords_8_11 = '0;
    logic [63:0]        i_coords_12_15 = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [2:0]         o_event_kind;
    logic [31:0]        o_entry_time;
    logic [63:0]        o_out_coords_0_3;
    logic [63:0]        o_out_coords_4_7;
    logic [63:0]        o_out_coords_8_11;
    logic [63:0]        o_out_coords_12_15;
    logic               o_last;
    logic               i_cfg_we = 1'b0;
    logic [19:0]        i_cfg_data = '0;

    logic               sky_valid [ENTRIES];
    logic [TIME_W-1:0]  sky_arrival [ENTRIES];
    logic [POINT_W-1:0] sky_point [ENTRIES];
    logic [TIME_W-1:0]  sky_tick;
    logic [LIFE_W-1:0]  sky_lifetime;

    t_event             pending_events[$];
    int                 error_count = 0;
    int                 idle_cycles = 0;
    int                 points_sent = 0;
    int                 events_seen = 0;
    bit                 out_stall_en = 1'b1;

    sliding_window_skyline #(
        .SKYLINE_ENTRIES(ENTRIES)
    ) u_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_coords_0_3(i_coords_0_3),
        .i_coords_4_7(i_coords_4_7),
        .i_coords_8_11(i_coords_8_11),
        .i_coords_12_15(i_coords_12_15),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_event_kind(o_event_kind),
        .o_entry_time(o_entry_time),
        .o_out_coords_0_3(o_out_coords_0_3),
        .o_out_coords_4_7(o_out_coords_4_7),
        .o_out_coords_8_11(o_out_coords_8_11),
        .o_out_coords_12_15(o_out_coords_12_15),
        .o_last(o_last),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic bit dominates(input logic [POINT_W-1:0] a, input logic [POINT_W-1:0] b);
        for (int d = 0; d < NUM_DIMS; d++) begin
            if (a[d*COORD_W +: COORD_W] > b[d*COORD_W +: COORD_W]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    task automatic push_event(input logic [KIND_W-1:0] kind, input logic [TIME_W-1:0] etime,
                              input logic [POINT_W-1:0] point);
        t_event ev;
        ev.kind = kind;
        ev.etime = etime;
        ev.point = point;
        ev.last = 1'b0;
        pending_events.push_back(ev);
    endtask

    task automatic predict_skyline(input logic [POINT_W-1:0] p);
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] age;
        bit                rejected;
        int                slot;
        int                first;
        t_event            ev;
        now = sky_tick;
        rejected = 1'b0;
        slot = -1;
        first = pending_events.size();
        for (int i = 0; i < ENTRIES; i++) begin
            if (sky_valid[i] && dominates(sky_point[i], p)) begin
                rejected = 1'b1;
            end
        end
        if (rejected) begin
            push_event(KIND_REJECT, now, p);
        end else begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (sky_valid[i] && dominates(p, sky_point[i])) begin
                    sky_valid[i] = 1'b0;
                    push_event(KIND_REMOVE, sky_arrival[i], sky_point[i]);
                end
            end
            for (int i = ENTRIES - 1; i >= 0; i--) begin
                if (!sky_valid[i]) begin
                    slot = i;
                end
            end
            if (slot < 0) begin
                push_event(KIND_DROP, now, p);
            end else begin
                sky_valid[slot] = 1'b1;
                sky_arrival[slot] = now;
                sky_point[slot] = p;
                push_event(KIND_ACCEPT, now, p);
            end
        end
        for (int i = 0; i < ENTRIES; i++) begin
            age = now - sky_arrival[i];
            if (sky_valid[i] && ({1'b0, age} + 33'd1 >= {13'd0, sky_lifetime})) begin
                sky_valid[i] = 1'b0;
                push_event(KIND_EXPIRE, sky_arrival[i], sky_point[i]);
            end
        end
        ev = pending_events[$];
        ev.last = 1'b1;
        pending_events[$] = ev;
        sky_tick = now + 1;
    endtask

    task automatic report_mismatch(input string what, input logic [POINT_W-1:0] got,
                                   input logic [POINT_W-1:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h", what, got, want);
    endtask

    task automatic random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return;
        end
        repeat (r < 93 ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge i_clk);
    endtask

    task automatic send_point(input logic [POINT_W-1:0] p);
        random_gap();
        i_coords_0_3 <= p[63:0];
        i_coords_4_7 <= p[127:64];
        i_coords_8_11 <= p[191:128];
        i_coords_12_15 <= p[255:192];
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        predict_skyline(p);
        points_sent++;
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain_and_settle();
        while (pending_events.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2 * ENTRIES + 20) @(negedge i_clk);
    endtask

    task automatic write_lifetime(input logic [LIFE_W-1:0] value);
        drain_and_settle();
        i_cfg_data <= value;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sky_lifetime = value;
    endtask

    function automatic logic [POINT_W-1:0] uniform_point(input int unsigned base, input int span);
        logic [POINT_W-1:0] p;
        for (int d = 0; d < NUM_DIMS; d++) begin
            p[d*COORD_W +: COORD_W] = 16'(base + $urandom_range(0, span));
        end
        return p;
    endfunction

    function automatic logic [POINT_W-1:0] wide_point();
        logic [POINT_W-1:0] p;
        for (int w = 0; w < 8; w++) begin
            p[w*32 +: 32] = $urandom;
        end
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_event want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            events_seen++;
            if (pending_events.size() == 0) begin
                report_mismatch("unexpected beat", {o_out_coords_12_15, o_out_coords_8_11,
                                o_out_coords_4_7, o_out_coords_0_3}, '0);
            end else begin
                want = pending_events.pop_front();
                if (o_event_kind !== want.kind) begin
                    report_mismatch("event_kind", POINT_W'(o_event_kind), POINT_W'(want.kind));
                end
                if (o_entry_time !== want.etime) begin
                    report_mismatch("entry_time", POINT_W'(o_entry_time), POINT_W'(want.etime));
                end
                if ({o_out_coords_12_15, o_out_coords_8_11, o_out_coords_4_7,
                     o_out_coords_0_3} !== want.point) begin
                    report_mismatch("coords", {o_out_coords_12_15, o_out_coords_8_11,
                                    o_out_coords_4_7, o_out_coords_0_3}, want.point);
                end
                if (o_last !== want.last) begin
                    report_mismatch("last", POINT_W'(o_last), POINT_W'(want.last));
                end
            end
        end
    end

    always @(negedge i_clk) begin
        int r;
        r = $urandom_range(0, 99);
        if (!out_stall_en || r < 60) begin
            i_out_ready <= 1'b1;
        end else if (r < 95) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 7) == 0);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("watchdog expired");
                $display("[sliding_window_skyline] ERROR");
                $finish;
            end
        end
    end

    task automatic test_extremes();
        send_point({POINT_W{1'b1}});
        send_point({POINT_W{1'b1}});
        send_point({16{16'h8000}});
        send_point({16{16'h8000}});
        send_point({{15{16'hffff}}, 16'h0000});
        send_point({16'h0000, {15{16'hffff}}});
        send_point({POINT_W{1'b0}});
        send_point({16{16'h5555}});
        send_point({16{16'haaaa}});
    endtask

    task automatic test_store_full();
        logic [POINT_W-1:0] p;
        write_lifetime(20'hfffff);
        for (int k = 0; k < ENTRIES + 4; k++) begin
            p = '0;
            p[(k % NUM_DIMS)*COORD_W +: COORD_W] = 16'hffff;
            p[((k + 1 + k / NUM_DIMS) % NUM_DIMS)*COORD_W +: COORD_W] = 16'(k);
            p = ~p;
            send_point(p);
        end
        send_point({POINT_W{1'b0}});
    endtask

    task automatic test_lifetimes();
        write_lifetime(20'd1);
        send_point(uniform_point(100, 50));
        send_point(uniform_point(100, 50));
        write_lifetime(20'd0);
        send_point(uniform_point(200, 50));
        write_lifetime(20'd3);
        for (int k = 0; k < 10; k++) begin
            send_point(uniform_point(1000, 4000));
        end
    endtask

    task automatic test_random();
        logic [LIFE_W-1:0] settings [5] = '{20'd2, 20'd7, 20'd40, 20'd10000, 20'hfffff};
        int r;
        for (int phase = 0; phase < 5; phase++) begin
            write_lifetime(settings[phase]);
            out_stall_en = (phase != 2);
            for (int k = 0; k < 70; k++) begin
                r = $urandom_range(0, 9);
                if (r < 6) begin
                    send_point(uniform_point($urandom_range(0, 60000), $urandom_range(0, 4000)));
                end else if (r < 9) begin
                    send_point(wide_point());
                end else begin
                    send_point(uniform_point(16'hff00, 255));
                end
            end
        end
        out_stall_en = 1'b1;
    endtask

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            sky_valid[i] = 1'b0;
            sky_arrival[i] = '0;
            sky_point[i] = '0;
        end
        sky_tick = '0;
        sky_lifetime = LIFETIME_RESET;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_extremes();
        test_store_full();
        test_lifetimes();
        test_random();
        drain_and_settle();
        $display("Sent %0d points and checked %0d result beats, lifetime from 0 to %0d.",
                 points_sent, events_seen, 20'hfffff);
        if (error_count == 0 && pending_events.size() == 0) begin
            $display("[sliding_window_skyline] OK");
        end else begin
            $display("[sliding_window_skyline] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
hw/rtl/sws_pkg.sv
hw/rtl/sws_cell.sv
hw/rtl/sliding_window_skyline.sv
tb/sv/tb_sliding_window_skyline.sv
